// ===== hdl/dahdsr_pkg.sv =====
// dahdsr_pkg: shared types, codes and constants of the envelope generator
// no dependencies; imported by every module of the block

package dahdsr_pkg;

  localparam int unsigned LVL_W  = 16;
  localparam int unsigned SAMP_W = 24;
  localparam int unsigned SL_W   = SAMP_W + 1;
  localparam int unsigned FRAC_W = 15;

  localparam logic [LVL_W-1:0] ONE_Q15 = 16'h8000;

  // key tracking pivots round the middle c
  localparam logic [6:0] KEY_CENTRE = 7'd60;

  // x / 60 == (x * RECIP_60) >> RECIP_SHIFT for every x below 2**23
  localparam logic [23:0] RECIP_60    = 24'd8947849;
  localparam int unsigned RECIP_SHIFT = 29;

  // serial divider retires this many quotient bits a cycle
  localparam int unsigned DIV_RADIX_BITS = 3;
  localparam int unsigned DIV_STEPS      = FRAC_W / DIV_RADIX_BITS;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = SAMP_W;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_NOTE_ON  = 2'd1,
    OP_NOTE_OFF = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STG_IDLE    = 3'd0,
    STG_DELAY   = 3'd1,
    STG_ATTACK  = 3'd2,
    STG_HOLD    = 3'd3,
    STG_DECAY   = 3'd4,
    STG_SUSTAIN = 3'd5,
    STG_RELEASE = 3'd6
  } stage_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY    = 3'd0,
    REG_ATTACK   = 3'd1,
    REG_HOLD     = 3'd2,
    REG_DECAY    = 3'd3,
    REG_RELEASE  = 3'd4,
    REG_SUSTAIN  = 3'd5,
    REG_KEYSCALE = 3'd6,
    REG_INVERT   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    op_t         operation;
    logic [15:0] note_velocity;
    logic [6:0]  note_number;
    logic [8:0]  sample_count;
  } req_t;

  typedef struct packed {
    logic [15:0] env_level;
    logic        active;
  } res_t;

  typedef struct packed {
    logic [SAMP_W-1:0] delay_samples;
    logic [SAMP_W-1:0] attack_samples;
    logic [SAMP_W-1:0] hold_samples;
    logic [SAMP_W-1:0] decay_samples;
    logic [SAMP_W-1:0] release_samples;
    logic [15:0]       sustain_level;
    logic [15:0]       key_scale_amount;
    logic              invert_output;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load_req;
    logic note_mul;
    logic note_recip;
    logic note_scale;
    logic note_fin;
    logic note_off;
    logic adv;
    logic div_start;
    logic mul;
    logic acc;
    logic res_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic stage_idle;
    logic count_zero;
    logic div_busy;
  } sts_t;

endpackage

// ===== hdl/dahdsr_envelope_generator.sv =====
// dahdsr_envelope_generator: top level of the delay/attack/hold/decay/sustain/release envelope
// holds the configuration and result registers; uses dahdsr_pkg, dahdsr_ctrl, dahdsr_dp
//
// usage
//   request channel (req_valid, req_stall, req): one request per item, taken when
//   req_valid is high and req_stall low. operation selects tick, note on or note off.
//   result channel (res_valid, res_stall, res): exactly one result per request,
//   in order. res is held while res_stall is high.
//   configuration (cfg_we, cfg_index, cfg_data): one register written per cycle with
//   cfg_we high; the user must write only while no request is in flight, which the
//   block itself does not enforce.
// sequencing
//   requests are worked on one at a time. note on works out the velocity product, the
//   key-tracking reciprocal, the scaled velocity and the stage start in turn. a tick runs
//   its samples one after another, the serial divider (3 quotient bits a cycle) working
//   out the remaining fraction of a ramp stage for each of them.
// reset
//   rst is synchronous and holds req_stall high: the envelope goes idle at level zero,
//   the registers take their defaults (stage lengths zero, sustain unity, no key tracking,
//   no inversion).
// stalls
//   the result register parts the channels: a new request is accepted while the last
//   result still waits; its own result then waits until the register frees up.

module dahdsr_envelope_generator
  import dahdsr_pkg::*;
#(
  parameter int unsigned VELOCITY_SCALE = 32768,
  parameter int unsigned MAX_BLOCK      = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_t                  req,
  output logic                  res_valid,
  input  logic                  res_stall,
  output res_t                  res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;
  res_t res_d;
  logic res_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delay_samples    <= '0;
      cfg.attack_samples   <= '0;
      cfg.hold_samples     <= '0;
      cfg.decay_samples    <= '0;
      cfg.release_samples  <= '0;
      cfg.sustain_level    <= ONE_Q15;
      cfg.key_scale_amount <= '0;
      cfg.invert_output    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DELAY:    cfg.delay_samples    <= cfg_data;
        REG_ATTACK:   cfg.attack_samples   <= cfg_data;
        REG_HOLD:     cfg.hold_samples     <= cfg_data;
        REG_DECAY:    cfg.decay_samples    <= cfg_data;
        REG_RELEASE:  cfg.release_samples  <= cfg_data;
        REG_SUSTAIN:  cfg.sustain_level    <= cfg_data[15:0];
        REG_KEYSCALE: cfg.key_scale_amount <= cfg_data[15:0];
        REG_INVERT:   cfg.invert_output    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // result register free when empty or being taken this cycle
  assign res_free = !res_valid || !res_stall;

  dahdsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_op    (req.operation),
    .res_free  (res_free),
    .sts       (sts),
    .cmd       (cmd),
    .req_stall (req_stall)
  );

  dahdsr_dp #(
    .VELOCITY_SCALE (VELOCITY_SCALE),
    .MAX_BLOCK      (MAX_BLOCK)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .res (res_d)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res <= res_d;
    end
  end

endmodule

// ===== hdl/dahdsr_div.sv =====
// dahdsr_div: restoring divider for the remaining fraction of a stage
// returns (dividend << 15) / divisor for dividend below divisor; uses dahdsr_pkg

module dahdsr_div
  import dahdsr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SAMP_W-1:0] dividend,
  input  logic [SAMP_W-1:0] divisor,
  output logic              busy,
  output logic [FRAC_W-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(DIV_STEPS + 1);

  logic [SAMP_W-1:0]         rem;
  logic [SAMP_W-1:0]         rem_next;
  logic [SAMP_W:0]           shifted;
  logic [DIV_RADIX_BITS-1:0] step_bits;
  logic [CNT_W-1:0]          cnt;

  // a few shift-subtract steps per cycle
  always_comb begin
    rem_next  = rem;
    shifted   = '0;
    step_bits = '0;
    for (int i = 0; i < DIV_RADIX_BITS; i++) begin
      shifted = {rem_next, 1'b0};
      if (shifted >= {1'b0, divisor}) begin
        shifted = shifted - {1'b0, divisor};
        step_bits[DIV_RADIX_BITS-1-i] = 1'b1;
      end
      rem_next = shifted[SAMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      quotient <= '0;
    end else if (busy) begin
      rem      <= rem_next;
      quotient <= {quotient[FRAC_W-DIV_RADIX_BITS-1:0], step_bits};
    end
  end

endmodule

// ===== hdl/dahdsr_dp.sv =====
// dahdsr_dp: envelope state, note-on velocity scaling and per-sample level datapath
// driven by command struct from dahdsr_ctrl; uses dahdsr_pkg and dahdsr_div

module dahdsr_dp
  import dahdsr_pkg::*;
#(
  parameter int unsigned VELOCITY_SCALE = 32768,
  parameter int unsigned MAX_BLOCK      = 256
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  req_t req,
  input  cmd_t cmd,
  output sts_t sts,
  output res_t res
);

  localparam int unsigned CNT_W = $clog2(MAX_BLOCK + 1);
  localparam logic [15:0] VEL_SCALE = 16'(VELOCITY_SCALE);

  function automatic logic [SAMP_W-1:0] stage_total(stage_t st, cfg_t c);
    logic [SAMP_W-1:0] t;
    case (st)
      STG_DELAY:   t = c.delay_samples;
      STG_ATTACK:  t = c.attack_samples;
      STG_HOLD:    t = c.hold_samples;
      STG_DECAY:   t = c.decay_samples;
      STG_RELEASE: t = c.release_samples;
      default:     t = '0;
    endcase
    return t;
  endfunction

  // envelope state
  stage_t          stage;
  stage_t          stage_next;
  logic [LVL_W-1:0] level;
  logic [LVL_W-1:0] level_adv;
  logic [LVL_W-1:0] level_acc;
  logic [LVL_W-1:0] vel;
  logic [LVL_W-1:0] vel_next;
  logic [SL_W-1:0]  sl;
  logic [SL_W-1:0]  sl_adv;

  // request fields
  op_t              op_q;
  logic [15:0]      velocity_q;
  logic [6:0]       key_q;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] n_sat;
  logic             tick_idle;

  // note-on pipeline
  logic             key_neg;
  logic [6:0]       key_dist;
  logic [31:0]      prod_v;
  logic [22:0]      prod_t;
  logic [46:0]      recip_full;
  logic [17:0]      q_recip;
  logic [16:0]      v_raw;
  logic signed [18:0] f_val;
  logic [33:0]      prod_f;
  logic             f_pos;
  logic [18:0]      v_pre;

  // per-sample pipeline
  logic [15:0]       sus_sat;
  logic [SAMP_W-1:0] total;
  logic              sl_pos;
  logic              needs_r;
  logic              sl_lt;
  logic              div_go;
  logic              div_busy;
  logic [FRAC_W-1:0] quotient;
  logic              use_div;
  logic [15:0]       r_q;
  logic [15:0]       r_eff;
  logic [15:0]       p_eff;
  logic [15:0]       mul_x;
  logic [15:0]       mul_y;
  logic [31:0]       prod_a;
  logic [31:0]       prod_b;
  logic [32:0]       acc_sum;
  logic [15:0]       lvl_clip;

  assign sus_sat = (cfg.sustain_level > ONE_Q15) ? ONE_Q15 : cfg.sustain_level;

  always_comb begin
    if (32'(req.sample_count) > MAX_BLOCK) begin
      n_sat = CNT_W'(MAX_BLOCK);
    end else begin
      n_sat = CNT_W'(req.sample_count);
    end
  end

  // velocity and key tracking
  assign key_dist   = (key_q < KEY_CENTRE) ? (KEY_CENTRE - key_q) : (key_q - KEY_CENTRE);
  assign recip_full = {24'd0, prod_t} * {23'd0, RECIP_60};
  assign f_val      = key_neg ? (19'sd32768 - $signed({1'b0, q_recip}))
                              : (19'sd32768 + $signed({1'b0, q_recip}));

  always_comb begin
    if (cfg.key_scale_amount == '0) begin
      v_pre = {2'b00, v_raw};
    end else if (f_pos) begin
      v_pre = prod_f[33:15];
    end else begin
      v_pre = '0;
    end
    vel_next = (v_pre > {3'b000, ONE_Q15}) ? ONE_Q15 : v_pre[15:0];
  end

  // stage advance at the start of a sample
  assign sl_pos = !sl[SL_W-1] && (sl != '0);

  always_comb begin
    stage_next = stage;
    sl_adv     = sl;
    level_adv  = level;
    if (!sl_pos) begin
      case (stage)
        STG_DELAY: begin
          stage_next = STG_ATTACK;
          sl_adv     = {1'b0, cfg.attack_samples};
        end
        STG_ATTACK: begin
          stage_next = STG_HOLD;
          sl_adv     = {1'b0, cfg.hold_samples};
          level_adv  = ONE_Q15;
        end
        STG_HOLD: begin
          stage_next = STG_DECAY;
          sl_adv     = {1'b0, cfg.decay_samples};
        end
        STG_DECAY: begin
          stage_next = STG_SUSTAIN;
          sl_adv     = '0;
          level_adv  = sus_sat;
        end
        STG_RELEASE: begin
          stage_next = STG_IDLE;
          level_adv  = '0;
        end
        default: ;
      endcase
    end
    // count down, pinned at minus one
    if (stage_next != STG_IDLE && sl_adv != '1) begin
      sl_adv = sl_adv - 1'b1;
    end
  end

  // remaining fraction, only the ramps need it
  assign total   = stage_total(stage, cfg);
  assign needs_r = (stage == STG_ATTACK || stage == STG_DECAY || stage == STG_RELEASE)
                   && sl_pos && (total != '0);
  assign sl_lt   = sl[SAMP_W-1:0] < total;
  assign div_go  = cmd.div_start && needs_r && sl_lt;

  dahdsr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (sl[SAMP_W-1:0]),
    .divisor  (total),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign r_eff = use_div ? {1'b0, quotient} : r_q;
  assign p_eff = ONE_Q15 - r_eff;

  always_comb begin
    case (stage)
      STG_ATTACK: begin
        mul_x = p_eff;
        mul_y = vel;
      end
      STG_DECAY: begin
        mul_x = vel;
        mul_y = r_eff;
      end
      STG_SUSTAIN: begin
        mul_x = sus_sat;
        mul_y = vel;
      end
      STG_RELEASE: begin
        mul_x = level;
        mul_y = r_eff;
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  assign acc_sum = {1'b0, prod_a} + {1'b0, prod_b};

  always_comb begin
    case (stage)
      STG_DELAY:   level_acc = '0;
      STG_HOLD:    level_acc = vel;
      STG_DECAY:   level_acc = acc_sum[30:15];
      STG_ATTACK,
      STG_SUSTAIN,
      STG_RELEASE: level_acc = prod_a[30:15];
      default:     level_acc = level;
    endcase
  end

  // envelope state and loop counter
  always_ff @(posedge clk) begin
    if (rst) begin
      stage     <= STG_IDLE;
      level     <= '0;
      vel       <= '0;
      sl        <= '0;
      count     <= '0;
      tick_idle <= 1'b0;
    end else begin
      if (cmd.load_req) begin
        count     <= n_sat;
        tick_idle <= (stage == STG_IDLE);
      end
      if (cmd.note_fin) begin
        vel   <= vel_next;
        level <= '0;
        if (cfg.delay_samples != '0) begin
          stage <= STG_DELAY;
          sl    <= {1'b0, cfg.delay_samples};
        end else begin
          stage <= STG_ATTACK;
          sl    <= {1'b0, cfg.attack_samples};
        end
      end
      if (cmd.note_off && stage != STG_IDLE) begin
        stage <= STG_RELEASE;
        sl    <= {1'b0, cfg.release_samples};
      end
      if (cmd.adv) begin
        stage <= stage_next;
        sl    <= sl_adv;
        level <= level_adv;
      end
      if (cmd.acc) begin
        level <= level_acc;
        count <= count - 1'b1;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_q       <= req.operation;
      velocity_q <= req.note_velocity;
      key_q      <= req.note_number;
    end
    if (cmd.note_mul) begin
      prod_v  <= {16'd0, velocity_q} * {16'd0, VEL_SCALE};
      prod_t  <= {16'd0, key_dist} * {7'd0, cfg.key_scale_amount};
      key_neg <= key_q < KEY_CENTRE;
    end
    if (cmd.note_recip) begin
      q_recip <= recip_full[RECIP_SHIFT +: 18];
      v_raw   <= prod_v[31:15];
    end
    if (cmd.note_scale) begin
      prod_f <= {17'd0, v_raw} * {17'd0, f_val[16:0]};
      f_pos  <= f_val > 19'sd0;
    end
    if (cmd.div_start) begin
      use_div <= needs_r && sl_lt;
      r_q     <= needs_r ? ONE_Q15 : '0;
    end
    if (cmd.mul) begin
      prod_a <= {16'd0, mul_x} * {16'd0, mul_y};
      prod_b <= {16'd0, sus_sat} * {16'd0, p_eff};
    end
  end

  assign sts.stage_idle = (stage == STG_IDLE);
  assign sts.count_zero = (count == '0);
  assign sts.div_busy   = div_busy;

  assign lvl_clip = (level > ONE_Q15) ? ONE_Q15 : level;

  always_comb begin
    res.active = (stage != STG_IDLE);
    if (op_q == OP_TICK) begin
      if (tick_idle) begin
        res.env_level = '0;
      end else if (cfg.invert_output) begin
        res.env_level = ONE_Q15 - lvl_clip;
      end else begin
        res.env_level = level;
      end
    end else begin
      res.env_level = level;
    end
  end

  a_sl_floor : assert property (@(posedge clk) disable iff (rst)
    !sl[SL_W-1] || (sl == '1))
    else $error("samples left went below minus one");

  a_level_range : assert property (@(posedge clk) disable iff (rst)
    level <= ONE_Q15)
    else $error("level above unity");

  a_idle_silent : assert property (@(posedge clk) disable iff (rst)
    (stage == STG_IDLE) |-> (level == '0))
    else $error("idle stage with non-zero level");

endmodule

// ===== hdl/dahdsr_ctrl.sv =====
// dahdsr_ctrl: sequencer for note-on scaling, note off and the per-sample tick loop
// one-hot state machine; talks to dahdsr_dp through cmd_t and sts_t from dahdsr_pkg

module dahdsr_ctrl
  import dahdsr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  op_t  req_op,
  input  logic res_free,
  input  sts_t sts,
  output cmd_t cmd,
  output logic req_stall
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_NOTE1 = 14'b00000000000010,
    S_NOTE2 = 14'b00000000000100,
    S_NOTE3 = 14'b00000000001000,
    S_NOTE4 = 14'b00000000010000,
    S_OFF   = 14'b00000000100000,
    S_LOOP  = 14'b00000001000000,
    S_ADV   = 14'b00000010000000,
    S_PREP  = 14'b00000100000000,
    S_DIV   = 14'b00001000000000,
    S_MUL   = 14'b00010000000000,
    S_ACC   = 14'b00100000000000,
    S_FIN   = 14'b01000000000000,
    S_SPARE = 14'b10000000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          unique case (req_op)
            OP_TICK:     state_next = S_LOOP;
            OP_NOTE_ON:  state_next = S_NOTE1;
            OP_NOTE_OFF: state_next = S_OFF;
            default:     state_next = S_FIN;
          endcase
        end
      end
      S_NOTE1: begin
        cmd.note_mul = 1'b1;
        state_next   = S_NOTE2;
      end
      S_NOTE2: begin
        cmd.note_recip = 1'b1;
        state_next     = S_NOTE3;
      end
      S_NOTE3: begin
        cmd.note_scale = 1'b1;
        state_next     = S_NOTE4;
      end
      S_NOTE4: begin
        cmd.note_fin = 1'b1;
        state_next   = S_FIN;
      end
      S_OFF: begin
        cmd.note_off = 1'b1;
        state_next   = S_FIN;
      end
      S_LOOP: begin
        if (sts.count_zero || sts.stage_idle) begin
          state_next = S_FIN;
        end else begin
          state_next = S_ADV;
        end
      end
      S_ADV: begin
        cmd.adv    = 1'b1;
        state_next = S_PREP;
      end
      S_PREP: begin
        if (sts.stage_idle) begin
          state_next = S_FIN;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_LOOP;
      end
      S_FIN: begin
        if (res_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // nothing is taken while reset is held
  assign req_stall = rst || (state != S_IDLE);

  a_div_in_wait : assert property (@(posedge clk) disable iff (rst)
    sts.div_busy |-> (state == S_DIV))
    else $error("divider running outside the wait state");

  a_note_on_starts : assert property (@(posedge clk) disable iff (rst)
    (state == S_NOTE4) |=> !sts.stage_idle)
    else $error("note on left the envelope idle");

  a_loop_exit : assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOP && (sts.count_zero || sts.stage_idle)) |=> (state == S_FIN))
    else $error("tick loop ran past its end");

endmodule

// ===== dv/dahdsr_env_checker.sv =====
// dahdsr_env_checker: watches the request, result and register ports of the envelope generator
// keeps its own copy of the envelope and flags every result that differs; uses dahdsr_pkg

module dahdsr_env_checker
  import dahdsr_pkg::*;
#(
  parameter int unsigned VELOCITY_SCALE = 32768,
  parameter int unsigned MAX_BLOCK      = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic                  req_stall,
  input  req_t                  req,
  input  logic                  res_valid,
  input  logic                  res_stall,
  input  res_t                  res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    checked_count,
  output int                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the register file and of the envelope
  cfg_t                    shadow_cfg;
  stage_t                  stg;
  logic [LVL_W-1:0]        lvl;
  logic [LVL_W-1:0]        vel_q15;
  logic signed [SL_W-1:0]  remaining;

  res_t awaited_levels[$];

  function automatic logic signed [SL_W-1:0] span(logic [SAMP_W-1:0] n);
    return $signed({1'b0, n});
  endfunction

  function automatic logic [SAMP_W-1:0] stage_len(stage_t s);
    case (s)
      STG_DELAY:   return shadow_cfg.delay_samples;
      STG_ATTACK:  return shadow_cfg.attack_samples;
      STG_HOLD:    return shadow_cfg.hold_samples;
      STG_DECAY:   return shadow_cfg.decay_samples;
      STG_RELEASE: return shadow_cfg.release_samples;
      default:     return '0;
    endcase
  endfunction

  function automatic longint unsigned sustain_sat();
    return (shadow_cfg.sustain_level > ONE_Q15) ? ONE_Q15 : shadow_cfg.sustain_level;
  endfunction

  // one sample of the envelope; returns 0 once it has fallen idle
  function automatic bit advance_sample();
    longint unsigned frac, prog, q, vel, sus, tot, lvl_wide;
    frac = 0;
    vel  = vel_q15;
    sus  = sustain_sat();
    if (remaining <= 0) begin
      case (stg)
        STG_DELAY: begin
          stg       = STG_ATTACK;
          remaining = span(shadow_cfg.attack_samples);
        end
        STG_ATTACK: begin
          stg       = STG_HOLD;
          remaining = span(shadow_cfg.hold_samples);
          lvl       = ONE_Q15;
        end
        STG_HOLD: begin
          stg       = STG_DECAY;
          remaining = span(shadow_cfg.decay_samples);
        end
        STG_DECAY: begin
          stg       = STG_SUSTAIN;
          remaining = 0;
          lvl       = sus;
        end
        STG_RELEASE: begin
          stg = STG_IDLE;
          lvl = '0;
        end
        default: ;
      endcase
    end
    if (stg == STG_IDLE) return 1'b0;

    if (remaining > -1) remaining = remaining - 1;

    tot = stage_len(stg);
    if (remaining > 0 && tot != 0) begin
      q    = longint'(remaining);
      q    = (q << FRAC_W) / tot;
      frac = (q > ONE_Q15) ? ONE_Q15 : q;
    end
    prog = ONE_Q15 - frac;

    case (stg)
      STG_DELAY:   lvl = '0;
      STG_ATTACK:  lvl = (prog * vel) >> FRAC_W;
      STG_HOLD:    lvl = vel;
      STG_DECAY:   lvl = (vel * frac + sus * prog) >> FRAC_W;
      STG_SUSTAIN: lvl = (sus * vel) >> FRAC_W;
      STG_RELEASE: begin
        lvl_wide = lvl;
        lvl      = (lvl_wide * frac) >> FRAC_W;
      end
      default: ;
    endcase
    return 1'b1;
  endfunction

  // works out the result of one request and moves the shadow envelope on
  function automatic res_t envelope_step(req_t r);
    res_t            out;
    longint          v, t, f;
    longint unsigned n, i, clamped;
    out.env_level = lvl;
    case (r.operation)
      OP_TICK: begin
        if (stg == STG_IDLE) begin
          out.env_level = '0;
        end else begin
          n = (r.sample_count > MAX_BLOCK) ? MAX_BLOCK : r.sample_count;
          i = 0;
          while (i < n && advance_sample()) i++;
          out.env_level = lvl;
          if (shadow_cfg.invert_output) begin
            clamped       = (lvl > ONE_Q15) ? ONE_Q15 : lvl;
            out.env_level = ONE_Q15 - clamped;
          end
        end
      end
      OP_NOTE_ON: begin
        v = (longint'(r.note_velocity) * VELOCITY_SCALE) >> FRAC_W;
        if (shadow_cfg.key_scale_amount != 0) begin
          t = (longint'(r.note_number) - longint'(KEY_CENTRE))
              * longint'(shadow_cfg.key_scale_amount);
          f = 32768 + t / 60;
          if (f <= 0) v = 0;
          else        v = (v * f) >> FRAC_W;
        end
        if (v > 32768) v = 32768;
        vel_q15 = v;
        if (shadow_cfg.delay_samples != 0) begin
          stg       = STG_DELAY;
          remaining = span(shadow_cfg.delay_samples);
        end else begin
          stg       = STG_ATTACK;
          remaining = span(shadow_cfg.attack_samples);
        end
        lvl           = '0;
        out.env_level = lvl;
      end
      OP_NOTE_OFF: begin
        if (stg != STG_IDLE) begin
          stg       = STG_RELEASE;
          remaining = span(shadow_cfg.release_samples);
        end
        out.env_level = lvl;
      end
      default: out.env_level = lvl;
    endcase
    out.active = (stg != STG_IDLE);
    return out;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      shadow_cfg               = '0;
      shadow_cfg.sustain_level = ONE_Q15;
      stg                      = STG_IDLE;
      lvl                      = '0;
      vel_q15                  = '0;
      remaining                = '0;
      awaited_levels.delete();
      outstanding              <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_DELAY:    shadow_cfg.delay_samples    = cfg_data;
          REG_ATTACK:   shadow_cfg.attack_samples   = cfg_data;
          REG_HOLD:     shadow_cfg.hold_samples     = cfg_data;
          REG_DECAY:    shadow_cfg.decay_samples    = cfg_data;
          REG_RELEASE:  shadow_cfg.release_samples  = cfg_data;
          REG_SUSTAIN:  shadow_cfg.sustain_level    = cfg_data[15:0];
          REG_KEYSCALE: shadow_cfg.key_scale_amount = cfg_data[15:0];
          REG_INVERT:   shadow_cfg.invert_output    = cfg_data[0];
          default: ;
        endcase
      end
      // results first: a result taken on this edge belongs to an earlier request
      if (res_valid && !res_stall) begin
        if (awaited_levels.size() == 0) begin
          fail_count++;
          $display("%0t: stray result, level %0d active %0b, no request outstanding",
                   $time, res.env_level, res.active);
        end else begin
          want = awaited_levels.pop_front();
          checked_count++;
          if (res.env_level !== want.env_level) begin
            fail_count++;
            $display("%0t: env_level expected %0d, actual %0d",
                     $time, want.env_level, res.env_level);
          end
          if (res.active !== want.active) begin
            fail_count++;
            $display("%0t: active expected %0b, actual %0b", $time, want.active, res.active);
          end
        end
      end
      if (req_valid && !req_stall) awaited_levels.push_back(envelope_step(req));
      outstanding <= awaited_levels.size();
    end
  end

  initial begin
    fail_count    = 0;
    checked_count = 0;
    outstanding   = 0;
  end

endmodule

// ===== dv/tb_dahdsr_envelope_generator.sv =====
// tb_dahdsr_envelope_generator: stimulus and verdict for the envelope generator
// drives notes and ticks through bursts and stalls, reprogramming between phases;
// uses dahdsr_pkg, dahdsr_envelope_generator and dahdsr_env_checker

module tb_dahdsr_envelope_generator
  import dahdsr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // request channel
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;

  // result channel
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  // register port
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // figures handed back by the checker
  int fail_count;
  int checked_count;
  int outstanding;

  // sender bookkeeping
  int   burst_left      = 0;
  bit   calm            = 1'b0;
  int   requests_sent   = 0;
  int   settings_loaded = 0;
  cfg_t settings;

  // receiver stall pattern
  logic [7:0] stall_phase = '0;
  int         stall_mode  = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  dahdsr_envelope_generator dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dahdsr_env_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req           (req),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .res           (res),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .checked_count (checked_count),
    .outstanding   (outstanding)
  );

  // receiver: each time the 8-bit phase counter wraps, pick between no stalls, scattered stalls and long runs
  always @(posedge clk) begin
    stall_phase <= stall_phase + 8'd1;
    if (stall_phase == 8'd0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0:       res_stall <= 1'b0;
      1:       res_stall <= ($urandom_range(0, 3) == 0);
      default: res_stall <= (stall_phase[3:0] < 4'd11);
    endcase
  end

  function automatic req_t make_req(op_t op, logic [15:0] vel, logic [6:0] key,
                                    logic [8:0] count);
    req_t r;
    r.operation     = op;
    r.note_velocity = vel;
    r.note_number   = key;
    r.sample_count  = count;
    return r;
  endfunction

  function automatic cfg_t make_settings(logic [SAMP_W-1:0] dly, logic [SAMP_W-1:0] att,
                                         logic [SAMP_W-1:0] hld, logic [SAMP_W-1:0] dec,
                                         logic [SAMP_W-1:0] rel, logic [15:0] sus,
                                         logic [15:0] keys, logic inv);
    cfg_t c;
    c.delay_samples    = dly;
    c.attack_samples   = att;
    c.hold_samples     = hld;
    c.decay_samples    = dec;
    c.release_samples  = rel;
    c.sustain_level    = sus;
    c.key_scale_amount = keys;
    c.invert_output    = inv;
    return c;
  endfunction

  // stage lengths: mostly short so that ticks walk through every stage
  function automatic logic [SAMP_W-1:0] rand_len();
    int k;
    k = $urandom_range(0, 9);
    if (k < 2)  return '0;
    if (k == 9) return $urandom_range(0, 24'hFFFFFF);
    return $urandom_range(1, 40);
  endfunction

  // tick sizes: mostly a handful of samples, now and then a full or oversized block
  function automatic logic [8:0] tick_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 6)  return $urandom_range(256, 511);
    if (k < 10) return $urandom_range(25, 255);
    return $urandom_range(0, 24);
  endfunction

  function automatic logic [15:0] rand_velocity();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 65535);
    return $urandom_range(0, 32768);
  endfunction

  // one request: opens a new burst when the last one is used up, after a random gap unless calm
  task automatic send_req(req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    requests_sent++;
  endtask

  // hold off until every result in flight has come back
  task automatic wait_drain();
    req_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // writes the whole register file, one register per cycle
  task automatic load_settings(cfg_t c);
    cfg_reg_t idx;
    logic [CFG_DATA_W-1:0] val;
    idx = REG_DELAY;
    repeat (8) begin
      case (idx)
        REG_DELAY:    val = c.delay_samples;
        REG_ATTACK:   val = c.attack_samples;
        REG_HOLD:     val = c.hold_samples;
        REG_DECAY:    val = c.decay_samples;
        REG_RELEASE:  val = c.release_samples;
        REG_SUSTAIN:  val = c.sustain_level;
        REG_KEYSCALE: val = c.key_scale_amount;
        default:      val = c.invert_output;
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      @(posedge clk);
      idx = idx.next();
    end
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // mostly whole notes with random content, the rest loose requests of any kind
  task automatic run_random(int quota);
    int done_items;
    int n;
    done_items = 0;
    while (done_items < quota) begin
      if ($urandom_range(0, 99) < 85) begin
        send_req(make_req(OP_NOTE_ON, rand_velocity(), $urandom_range(0, 127), $urandom));
        n = $urandom_range(1, 6);
        repeat (n) send_req(make_req(OP_TICK, $urandom, $urandom, tick_len()));
        done_items += n + 1;
        if ($urandom_range(0, 9) != 0) begin
          send_req(make_req(OP_NOTE_OFF, $urandom, $urandom, $urandom));
          n = $urandom_range(1, 4);
          repeat (n) send_req(make_req(OP_TICK, $urandom, $urandom, tick_len()));
          done_items += n + 1;
        end
      end else begin
        n = $urandom_range(1, 3);
        repeat (n)
          send_req(make_req(op_t'($urandom_range(0, 3)), rand_velocity(),
                            $urandom_range(0, 127), tick_len()));
        done_items += n;
      end
    end
  endtask

  initial begin
    cfg_t c;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults after reset: zero stage lengths, unity sustain, no tracking or inversion
    send_req(make_req(OP_TICK, 16'h0000, 7'd0, 9'h1FF));      // tick while idle
    send_req(make_req(OP_NOTE_OFF, 16'h0000, 7'd0, 9'd0));    // release while idle is ignored
    send_req(make_req(OP_NONE, 16'hFFFF, 7'h7F, 9'h1FF));     // unused operation
    send_req(make_req(OP_NOTE_ON, 16'hFFFF, 7'd127, 9'd0));   // velocity above unity clamps
    send_req(make_req(OP_TICK, 16'hFFFF, 7'h7F, 9'd0));       // empty tick
    send_req(make_req(OP_TICK, 16'h0000, 7'd0, 9'd3));
    send_req(make_req(OP_NOTE_OFF, 16'h0000, 7'd0, 9'd0));
    send_req(make_req(OP_TICK, 16'h0000, 7'd0, 9'd2));        // zero-length release

    // short stages, sustain register above unity, full key tracking, inverted output
    wait_drain();
    load_settings(make_settings(24'd2, 24'd5, 24'd1, 24'd4, 24'd3, 16'hFFFF, 16'hFFFF, 1'b1));
    send_req(make_req(OP_NOTE_ON, 16'd16384, 7'd0, 9'd0));    // tracking drives velocity to zero
    send_req(make_req(OP_TICK, 16'd0, 7'd0, 9'd20));
    send_req(make_req(OP_NOTE_ON, 16'd32768, 7'd127, 9'd0));  // tracking pushes past unity
    send_req(make_req(OP_TICK, 16'd0, 7'd0, 9'd1));
    send_req(make_req(OP_TICK, 16'd0, 7'd0, 9'd1));
    send_req(make_req(OP_TICK, 16'd0, 7'd0, 9'd4));
    send_req(make_req(OP_TICK, 16'd0, 7'd0, 9'd8));
    send_req(make_req(OP_NOTE_OFF, 16'd0, 7'd0, 9'd0));
    send_req(make_req(OP_TICK, 16'd0, 7'd0, 9'd2));
    send_req(make_req(OP_TICK, 16'd0, 7'd0, 9'h1FF));         // oversized, release ends inside
    send_req(make_req(OP_TICK, 16'd0, 7'd0, 9'd1));           // idle again, not inverted

    // no delay, longest other stages, zero sustain, smallest tracking step
    wait_drain();
    c = make_settings(24'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'd0, 16'd1, 1'b0);
    load_settings(c);
    send_req(make_req(OP_NOTE_ON, 16'h5555, 7'd59, 9'd0));
    send_req(make_req(OP_TICK, 16'hAAAA, 7'h2A, 9'd256));     // full block of a long attack
    send_req(make_req(OP_NOTE_OFF, 16'd0, 7'd0, 9'd0));
    send_req(make_req(OP_TICK, 16'd0, 7'd0, 9'd7));

    // release cut short while it runs: remaining fraction pins at unity
    wait_drain();
    c.attack_samples  = 24'd3;
    c.release_samples = 24'd5;
    load_settings(c);
    send_req(make_req(OP_TICK, 16'd0, 7'd0, 9'd3));
    send_req(make_req(OP_TICK, 16'd0, 7'd0, 9'd9));

    // random phases: fresh registers each time, the envelope carries over between them
    for (int phase = 0; phase < 6; phase++) begin
      wait_drain();
      if ($urandom_range(0, 9) == 0)
        settings.sustain_level = $urandom_range(32769, 65535);
      settings = make_settings(rand_len(), rand_len(), rand_len(), rand_len(), rand_len(),
                               ($urandom_range(0, 9) == 0) ? $urandom_range(32769, 65535)
                                                            : $urandom_range(0, 32768),
                               ($urandom_range(0, 1) == 0) ? 16'd0 : $urandom_range(1, 65535),
                               $urandom_range(0, 1));
      load_settings(settings);
      calm = (phase % 3 == 1);
      run_random(16);
    end

    // drain, then give the block a little longer in case anything else turns up
    wait_drain();
    repeat (50) @(posedge clk);

    $display("run: %0d requests sent, %0d results checked, %0d register settings loaded",
             requests_sent, checked_count, settings_loaded);
    $display("covered idle, delay, attack, hold, decay, sustain and release under stalls");
    if (fail_count == 0 && outstanding == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // watchdog: several times the slowest legal run
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
